/* sv/assert_macros.svh */
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(name, clk, rst, cond, msg)
`define ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

/* sv/bitp_pkg.sv */
package bitp_pkg;

   localparam int STACK_DEPTH_DEFAULT = 32;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   // stack codes, ordered by priority
   localparam logic [2:0] OPC_LPAR  = 3'd0;
   localparam logic [2:0] OPC_TILDE = 3'd1;
   localparam logic [2:0] OPC_GT    = 3'd2;
   localparam logic [2:0] OPC_BAR   = 3'd3;
   localparam logic [2:0] OPC_AMP   = 3'd4;
   localparam logic [2:0] OPC_MINUS = 3'd5;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_NO_OPEN  = 3'd1;
   localparam logic [2:0] ERR_UNCLOSED = 3'd2;
   localparam logic [2:0] ERR_UNKNOWN  = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW = 3'd4;

   localparam logic [2:0] CLS_SKIP = 3'd0;
   localparam logic [2:0] CLS_OPND = 3'd1;
   localparam logic [2:0] CLS_OP   = 3'd2;
   localparam logic [2:0] CLS_LPAR = 3'd3;
   localparam logic [2:0] CLS_RPAR = 3'd4;
   localparam logic [2:0] CLS_BAD  = 3'd5;

   localparam logic [1:0] SEL_CHAR = 2'd0;
   localparam logic [1:0] SEL_TOP  = 2'd1;
   localparam logic [1:0] SEL_ERR  = 2'd2;

   typedef struct packed {
      logic [7:0] token_out;
      logic       token_valid;
      logic [2:0] error_code;
   } bitp_tok_type;

   typedef struct packed {
      bitp_tok_type tok;
      logic         expr_done;
      logic         last_of_run;
   } bitp_rsp_type;

   typedef struct packed {
      logic       load;
      logic       emit;
      logic [1:0] emit_sel;
      logic [2:0] err_code;
      logic       err;
      logic       push;
      logic       push_lpar;
      logic       pop;
      logic       clr_drain;
      logic       finish;
   } bitp_cmd_type;

   typedef struct packed {
      logic [2:0] cls;
      logic       drain;
      logic       end_of_expr;
      logic       empty;
      logic       full;
      logic       top_is_lpar;
      logic       op_le_top;
      logic       pend_vld;
      logic       out_free;
   } bitp_status_type;

   function automatic logic [2:0] op_code(input logic [7:0] c);
      logic [2:0] r;
      case (c)
         CH_TILDE: r = OPC_TILDE;
         CH_GT:    r = OPC_GT;
         CH_BAR:   r = OPC_BAR;
         CH_AMP:   r = OPC_AMP;
         CH_MINUS: r = OPC_MINUS;
         default:  r = OPC_LPAR;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] code_char(input logic [2:0] code);
      logic [7:0] r;
      case (code)
         OPC_TILDE: r = CH_TILDE;
         OPC_GT:    r = CH_GT;
         OPC_BAR:   r = CH_BAR;
         OPC_AMP:   r = CH_AMP;
         OPC_MINUS: r = CH_MINUS;
         default:   r = CH_LPAR;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] classify(input logic [7:0] c);
      logic [2:0] r;
      if (c <= CH_SPACE) begin
         r = CLS_SKIP;
      end else if (c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ], CH_ZERO, CH_ONE}) begin
         r = CLS_OPND;
      end else if (op_code(c) != OPC_LPAR) begin
         r = CLS_OP;
      end else if (c == CH_LPAR) begin
         r = CLS_LPAR;
      end else if (c == CH_RPAR) begin
         r = CLS_RPAR;
      end else begin
         r = CLS_BAD;
      end
      return r;
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c inside {[CH_LA:CH_LZ]}) ? c - CASE_DELTA : c;
   endfunction

endpackage

/* sv/bitp_if.sv */
interface bitp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_expr;

   modport source (output valid, output char_in, output end_of_expr, input ready);
   modport sink (input valid, input char_in, input end_of_expr, output ready);
endinterface

interface bitp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] token_out;
   logic       token_valid;
   logic [2:0] error_code;
   logic       expr_done;
   logic       last_of_run;

   modport source (output valid, output token_out, output token_valid, output error_code,
                   output expr_done, output last_of_run, input ready);
   modport sink (input valid, input token_out, input token_valid, input error_code,
                 input expr_done, input last_of_run, output ready);
endinterface

/* sv/bitp_datapath.sv */
`include "assert_macros.svh"

module bitp_datapath #(
   parameter int STACK_DEPTH = bitp_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [7:0]                  req_char_in,
   input  logic                        req_end_of_expr,
   input  bitp_pkg::bitp_cmd_type      cmd,
   output bitp_pkg::bitp_status_type   status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bitp_pkg::bitp_rsp_type      rsp_data
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   drain_ff, drain_in;
   logic                   end_ff, end_in;
   logic [2:0]             op_ff, op_in;
   logic [2:0]             top_ff;
   bitp_pkg::bitp_tok_type pend_ff, pend_in;
   logic                   pend_vld_ff, pend_vld_in;
   bitp_pkg::bitp_rsp_type out_ff, out_in;
   logic                   out_vld_ff, out_vld_in;

   logic [2:0]             stack_mem [STACK_DEPTH];

   logic                   cur_end;
   logic                   out_free;
   bitp_pkg::bitp_tok_type new_tok;
   logic [2:0]             wr_code;
   logic [ADDR_W-1:0]      wr_addr;
   logic [ADDR_W-1:0]      rd_addr;

   assign cur_end  = cmd.load ? req_end_of_expr : end_ff;
   assign out_free = !out_vld_ff || rsp_ready;
   assign wr_code  = cmd.push_lpar ? bitp_pkg::OPC_LPAR : op_ff;
   assign wr_addr  = count_ff[ADDR_W-1:0];
   assign rd_addr  = ADDR_W'(count_in - CNT_W'(1));

   always_comb begin
      new_tok = '0;
      case (cmd.emit_sel)
         bitp_pkg::SEL_CHAR: begin
            new_tok.token_out   = bitp_pkg::upcase(req_char_in);
            new_tok.token_valid = 1'b1;
         end
         bitp_pkg::SEL_TOP: begin
            new_tok.token_out   = bitp_pkg::code_char(top_ff);
            new_tok.token_valid = 1'b1;
         end
         bitp_pkg::SEL_ERR: begin
            new_tok.error_code = cmd.err_code;
         end
         default: begin
            new_tok = '0;
         end
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      drain_in    = drain_ff;
      end_in      = end_ff;
      op_in       = op_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff && !rsp_ready;

      if (cmd.load) begin
         end_in = req_end_of_expr;
         op_in  = bitp_pkg::op_code(req_char_in);
      end

      // a new result pushes the held one out; last flag is known only at finish
      if (cmd.emit) begin
         if (pend_vld_ff) begin
            out_in     = '{tok: pend_ff, expr_done: 1'b0, last_of_run: 1'b0};
            out_vld_in = 1'b1;
         end
         pend_in     = new_tok;
         pend_vld_in = 1'b1;
      end

      if (cmd.finish) begin
         out_vld_in  = 1'b1;
         pend_vld_in = 1'b0;
         if (pend_vld_ff) begin
            out_in = '{tok: pend_ff, expr_done: end_ff, last_of_run: 1'b1};
         end else begin
            out_in = '{tok: '0, expr_done: 1'b1, last_of_run: 1'b1};
         end
         if (end_ff) begin
            count_in = '0;
         end
      end

      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.err) begin
         count_in = '0;
         drain_in = !cur_end;
      end
      if (cmd.clr_drain) begin
         count_in = '0;
         drain_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         drain_ff    <= 1'b0;
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         drain_ff    <= drain_in;
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff  <= end_in;
      op_ff   <= op_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   // stack memory; top_ff tracks the entry at count - 1
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[wr_addr] <= wr_code;
      end
      if (count_in != '0) begin
         top_ff <= cmd.push ? wr_code : stack_mem[rd_addr];
      end
   end

   assign status = '{
      cls:         bitp_pkg::classify(req_char_in),
      drain:       drain_ff,
      end_of_expr: cur_end,
      empty:       count_ff == '0,
      full:        count_ff == CNT_W'(STACK_DEPTH),
      top_is_lpar: top_ff == bitp_pkg::OPC_LPAR,
      op_le_top:   op_ff <= top_ff,
      pend_vld:    pend_vld_ff,
      out_free:    out_free
   };

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   `ASSERT_IMPLY(a_emit_room, clock, reset, cmd.emit && pend_vld_ff, out_free, "emit overruns output")
   `ASSERT_IMPLY(a_finish_has_item, clock, reset, cmd.finish, pend_vld_ff || end_ff, "finish with nothing")
   `ASSERT_IMPLY(a_push_room, clock, reset, cmd.push, count_ff < CNT_W'(STACK_DEPTH), "push on full stack")
   `ASSERT_IMPLY(a_pop_nonempty, clock, reset, cmd.pop, count_ff != '0, "pop on empty stack")
   `ASSERT_NEXT(a_end_clears, clock, reset, cmd.finish && end_ff, count_ff == '0, "stack kept after end")

endmodule

/* sv/bitp_ctrl.sv */
module bitp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bitp_pkg::bitp_status_type   status,
   output bitp_pkg::bitp_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_OPPOP = 3'd1;
   localparam logic [2:0] S_RPAR  = 3'd2;
   localparam logic [2:0] S_FLUSH = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       emit_ok;
   logic [2:0] after_item;

   assign emit_ok    = !status.pend_vld || status.out_free;
   assign after_item = status.end_of_expr ? S_FLUSH : (status.pend_vld ? S_DONE : S_IDLE);

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.drain) begin
                  if (status.end_of_expr) begin
                     cmd.clr_drain = 1'b1;
                     state_in      = S_DONE;
                  end
               end else begin
                  case (status.cls)
                     bitp_pkg::CLS_SKIP: begin
                        state_in = status.end_of_expr ? S_FLUSH : S_IDLE;
                     end
                     bitp_pkg::CLS_OPND: begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = bitp_pkg::SEL_CHAR;
                        state_in     = status.end_of_expr ? S_FLUSH : S_DONE;
                     end
                     bitp_pkg::CLS_OP: begin
                        state_in = S_OPPOP;
                     end
                     bitp_pkg::CLS_LPAR: begin
                        if (status.full) begin
                           cmd.emit     = 1'b1;
                           cmd.emit_sel = bitp_pkg::SEL_ERR;
                           cmd.err_code = bitp_pkg::ERR_OVERFLOW;
                           cmd.err      = 1'b1;
                           state_in     = S_DONE;
                        end else begin
                           cmd.push      = 1'b1;
                           cmd.push_lpar = 1'b1;
                           state_in      = status.end_of_expr ? S_FLUSH : S_IDLE;
                        end
                     end
                     bitp_pkg::CLS_RPAR: begin
                        state_in = S_RPAR;
                     end
                     default: begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = bitp_pkg::SEL_ERR;
                        cmd.err_code = bitp_pkg::ERR_UNKNOWN;
                        cmd.err      = 1'b1;
                        state_in     = S_DONE;
                     end
                  endcase
               end
            end
         end
         S_OPPOP: begin
            if (!status.empty && !status.top_is_lpar && status.op_le_top) begin
               if (emit_ok) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = bitp_pkg::SEL_TOP;
                  cmd.pop      = 1'b1;
               end
            end else if (status.full) begin
               if (emit_ok) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = bitp_pkg::SEL_ERR;
                  cmd.err_code = bitp_pkg::ERR_OVERFLOW;
                  cmd.err      = 1'b1;
                  state_in     = S_DONE;
               end
            end else begin
               cmd.push = 1'b1;
               state_in = after_item;
            end
         end
         S_RPAR: begin
            if (status.empty) begin
               if (emit_ok) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = bitp_pkg::SEL_ERR;
                  cmd.err_code = bitp_pkg::ERR_NO_OPEN;
                  cmd.err      = 1'b1;
                  state_in     = S_DONE;
               end
            end else if (status.top_is_lpar) begin
               cmd.pop  = 1'b1;
               state_in = after_item;
            end else if (emit_ok) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = bitp_pkg::SEL_TOP;
               cmd.pop      = 1'b1;
            end
         end
         S_FLUSH: begin
            if (status.empty) begin
               state_in = S_DONE;
            end else if (status.top_is_lpar) begin
               if (emit_ok) begin
                  cmd.emit     = 1'b1;
                  cmd.emit_sel = bitp_pkg::SEL_ERR;
                  cmd.err_code = bitp_pkg::ERR_UNCLOSED;
                  cmd.err      = 1'b1;
                  state_in     = S_DONE;
               end
            end else if (emit_ok) begin
               cmd.emit     = 1'b1;
               cmd.emit_sel = bitp_pkg::SEL_TOP;
               cmd.pop      = 1'b1;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/boolean_infix_to_postfix.sv */
// Infix to postfix converter, one byte per item.
// An item is accepted in IDLE; OPPOP or RPAR pops operators from the stack one by one and
// then evaluates the operator or ')', and DONE hands over its last result. A new byte is
// taken only in IDLE, after the last item; pops and results wait while the output is held.
// A result is held until the next result or the finish sets its last flag, then goes to rsp.
// Synchronous reset empties the stack count and clears draining; stack contents are kept.
module boolean_infix_to_postfix #(
   parameter int STACK_DEPTH = bitp_pkg::STACK_DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   bitp_req_if.sink   req_if,
   bitp_rsp_if.source rsp_if
);

   bitp_pkg::bitp_cmd_type    cmd;
   bitp_pkg::bitp_status_type status;
   bitp_pkg::bitp_rsp_type    rsp_data;
   logic                      rsp_valid;

   bitp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bitp_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_char_in     (req_if.char_in),
      .req_end_of_expr (req_if.end_of_expr),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_data        (rsp_data)
   );

   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.token_out   = rsp_data.tok.token_out;
   assign rsp_if.token_valid = rsp_data.tok.token_valid;
   assign rsp_if.error_code  = rsp_data.tok.error_code;
   assign rsp_if.expr_done   = rsp_data.expr_done;
   assign rsp_if.last_of_run = rsp_data.last_of_run;

endmodule
